>>> rtl/dpb_pkg.sv
`default_nettype none

package dpb_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_INV_DEPTH_SCALE = 3'd0,
      REG_CENTER_X        = 3'd1,
      REG_CENTER_Y        = 3'd2,
      REG_INV_FOCAL_X     = 3'd3,
      REG_INV_FOCAL_Y     = 3'd4
   } reg_index_type;

   localparam logic [23:0] RST_INV_DEPTH_SCALE = 24'd16777;
   localparam logic [15:0] RST_CENTER_X        = 16'd5120;
   localparam logic [15:0] RST_CENTER_Y        = 16'd3840;
   localparam logic [23:0] RST_INV_FOCAL_X     = 24'd32263;
   localparam logic [23:0] RST_INV_FOCAL_Y     = 24'd32263;

   typedef struct packed {
      logic [23:0] inv_depth_scale;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [23:0] inv_focal_x;
      logic [23:0] inv_focal_y;
   } cfg_type;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

`default_nettype wire

>>> rtl/dpb_csr.sv
`default_nettype none

module dpb_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [dpb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [dpb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dpb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output dpb_pkg::cfg_type                    cfg
);

   dpb_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic [2:0]       idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_depth_scale <= dpb_pkg::RST_INV_DEPTH_SCALE;
         cfg_ff.center_x        <= dpb_pkg::RST_CENTER_X;
         cfg_ff.center_y        <= dpb_pkg::RST_CENTER_Y;
         cfg_ff.inv_focal_x     <= dpb_pkg::RST_INV_FOCAL_X;
         cfg_ff.inv_focal_y     <= dpb_pkg::RST_INV_FOCAL_Y;
      end else if (wr_en) begin
         case (idx)
            dpb_pkg::REG_INV_DEPTH_SCALE: cfg_ff.inv_depth_scale <= csr_pwdata[23:0];
            dpb_pkg::REG_CENTER_X:        cfg_ff.center_x        <= csr_pwdata[15:0];
            dpb_pkg::REG_CENTER_Y:        cfg_ff.center_y        <= csr_pwdata[15:0];
            dpb_pkg::REG_INV_FOCAL_X:     cfg_ff.inv_focal_x     <= csr_pwdata[23:0];
            dpb_pkg::REG_INV_FOCAL_Y:     cfg_ff.inv_focal_y     <= csr_pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         dpb_pkg::REG_INV_DEPTH_SCALE: csr_prdata = {8'd0, cfg_ff.inv_depth_scale};
         dpb_pkg::REG_CENTER_X:        csr_prdata = {16'd0, cfg_ff.center_x};
         dpb_pkg::REG_CENTER_Y:        csr_prdata = {16'd0, cfg_ff.center_y};
         dpb_pkg::REG_INV_FOCAL_X:     csr_prdata = {8'd0, cfg_ff.inv_focal_x};
         dpb_pkg::REG_INV_FOCAL_Y:     csr_prdata = {8'd0, cfg_ff.inv_focal_y};
         default:                      csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/dpb_axis.sv
`default_nettype none

module dpb_axis (
   input  wire                        clock,
   input  wire dpb_pkg::stage_en_type en,
   input  wire  [15:0]                d_mag,
   input  wire                        d_neg,
   input  wire  [31:0]                z,
   input  wire  [23:0]                inv,
   output logic [31:0]                coord
);

   logic [47:0] t_ff, t_in;
   logic        neg2_ff, neg3_ff;
   logic [59:0] ph_ff, ph_in;
   logic [59:0] pl_ff, pl_in;
   logic [60:0] sum;
   logic [44:0] mag;
   logic [31:0] coord_ff, coord_in;

   assign t_in  = 48'(d_mag) * 48'(z);
   assign ph_in = 60'(t_ff) * 60'(inv[23:12]);
   assign pl_in = 60'(t_ff) * 60'(inv[11:0]);

   assign sum = 61'(ph_ff) + 61'(pl_ff[59:12]);
   assign mag = sum[60:16];

   always_comb begin
      if (neg3_ff) begin
         if (mag > 45'h0_8000_0000) begin
            coord_in = 32'h8000_0000;
         end else begin
            coord_in = 32'd0 - mag[31:0];
         end
      end else begin
         if (mag > 45'h0_7FFF_FFFF) begin
            coord_in = 32'h7FFF_FFFF;
         end else begin
            coord_in = mag[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         t_ff    <= t_in;
         neg2_ff <= d_neg;
      end
      if (en.s3) begin
         ph_ff   <= ph_in;
         pl_ff   <= pl_in;
         neg3_ff <= neg2_ff;
      end
      if (en.s4) begin
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

`default_nettype wire

>>> rtl/depth_pixel_backprojection_unit.sv
// Depth pixel back-projection unit.
// Input channel (req_): one word per pixel with column, row, raw depth and
// colour bytes; accepted when req_valid is high and req_stall is low.
// Result channel (rsp_): one word per pixel with has_point, point_x/y/z in
// Q16.16 and the colour bytes, in input order; taken when rsp_valid is high
// and rsp_stall is low. Pixels with zero depth or a coordinate at or beyond
// COORD_LIMIT give has_point = 0 and zero coordinates.
// Stages, in order: depth scaling and the centered offsets, then the
// offset-by-depth multiply, then the split multiply by the reciprocal focal
// length, then the sum and saturation, one stage each.
// Throughput is one pixel per cycle while the receiver does not stall;
// each of the four stages holds one word, and a stage loads whenever it
// is empty or the next one moves.
// While the receiver stalls, the words in flight hold and empty stages keep
// filling; req_stall rises only once all four stages hold a word.
// Registers sit on the csr_ port (APB, always ready) at byte address 4*i.
// Write them only while no pixel is in flight.
// Reset (synchronous) empties the pipeline and restores register defaults.
`default_nettype none

module depth_pixel_backprojection_unit #(
   parameter int unsigned COORD_LIMIT = 4096
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire  [11:0]                     req_pixel_col,
   input  wire  [11:0]                     req_pixel_row,
   input  wire  [15:0]                     req_depth_raw,
   input  wire  [7:0]                      req_blue_in,
   input  wire  [7:0]                      req_green_in,
   input  wire  [7:0]                      req_red_in,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic                            rsp_has_point,
   output logic signed [31:0]              rsp_point_x,
   output logic signed [31:0]              rsp_point_y,
   output logic [31:0]                     rsp_point_z,
   output logic [7:0]                      rsp_blue_out,
   output logic [7:0]                      rsp_green_out,
   output logic [7:0]                      rsp_red_out,
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire  [dpb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [dpb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dpb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam logic [16:0] LIMIT = 17'(COORD_LIMIT);

   dpb_pkg::cfg_type      cfg;
   dpb_pkg::stage_en_type en;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   logic        hp_in;
   logic [39:0] zprod;
   logic [17:0] dx, dy;
   logic [15:0] mx_in, my_in;

   logic        hp1_ff, hp2_ff, hp3_ff, hp4_ff;
   logic [31:0] z1_ff, z2_ff, z3_ff, z4_ff;
   logic [15:0] mx1_ff, my1_ff;
   logic        nx1_ff, ny1_ff;
   logic [23:0] rgb1_ff, rgb2_ff, rgb3_ff, rgb4_ff;
   logic [31:0] px, py;

   dpb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign rdy4 = ~v4_ff | ~rsp_stall;
   assign rdy3 = ~v3_ff | rdy4;
   assign rdy2 = ~v2_ff | rdy3;
   assign rdy1 = ~v1_ff | rdy2;

   assign en.s2 = rdy2;
   assign en.s3 = rdy3;
   assign en.s4 = rdy4;

   assign req_stall = ~rdy1;

   assign hp_in = (req_depth_raw != 16'd0) &&
                  ({5'd0, req_pixel_col} < LIMIT) &&
                  ({5'd0, req_pixel_row} < LIMIT);
   assign zprod = 40'(req_depth_raw) * 40'(cfg.inv_depth_scale);
   assign dx    = {2'b00, req_pixel_col, 4'b0000} - {2'b00, cfg.center_x};
   assign dy    = {2'b00, req_pixel_row, 4'b0000} - {2'b00, cfg.center_y};
   assign mx_in = dx[17] ? 16'(18'd0 - dx) : dx[15:0];
   assign my_in = dy[17] ? 16'(18'd0 - dy) : dy[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         hp1_ff  <= hp_in;
         z1_ff   <= hp_in ? zprod[39:8] : 32'd0;
         mx1_ff  <= hp_in ? mx_in : 16'd0;
         my1_ff  <= hp_in ? my_in : 16'd0;
         nx1_ff  <= hp_in & dx[17];
         ny1_ff  <= hp_in & dy[17];
         rgb1_ff <= {req_red_in, req_green_in, req_blue_in};
      end
      if (rdy2) begin
         hp2_ff  <= hp1_ff;
         z2_ff   <= z1_ff;
         rgb2_ff <= rgb1_ff;
      end
      if (rdy3) begin
         hp3_ff  <= hp2_ff;
         z3_ff   <= z2_ff;
         rgb3_ff <= rgb2_ff;
      end
      if (rdy4) begin
         hp4_ff  <= hp3_ff;
         z4_ff   <= z3_ff;
         rgb4_ff <= rgb3_ff;
      end
   end

   dpb_axis u_axis_x (
      .clock (clock),
      .en    (en),
      .d_mag (mx1_ff),
      .d_neg (nx1_ff),
      .z     (z1_ff),
      .inv   (cfg.inv_focal_x),
      .coord (px)
   );

   dpb_axis u_axis_y (
      .clock (clock),
      .en    (en),
      .d_mag (my1_ff),
      .d_neg (ny1_ff),
      .z     (z1_ff),
      .inv   (cfg.inv_focal_y),
      .coord (py)
   );

   assign rsp_valid     = v4_ff;
   assign rsp_has_point = hp4_ff;
   assign rsp_point_x   = px;
   assign rsp_point_y   = py;
   assign rsp_point_z   = z4_ff;
   assign rsp_blue_out  = rgb4_ff[7:0];
   assign rsp_green_out = rgb4_ff[15:8];
   assign rsp_red_out   = rgb4_ff[23:16];

endmodule

`default_nettype wire

>>> rtl/dpb_checker.sv
`default_nettype none

module dpb_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_stall,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input wire               rsp_has_point,
   input wire signed [31:0] rsp_point_x,
   input wire signed [31:0] rsp_point_y,
   input wire        [31:0] rsp_point_z
);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_no_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_point |->
         rsp_point_x == 32'sd0 && rsp_point_y == 32'sd0 && rsp_point_z == 32'd0)
      else $error("coordinates nonzero without a point");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while the output moves");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_y) &&
         $stable(rsp_point_z) && $stable(rsp_has_point))
      else $error("stalled result word changed");

endmodule

bind depth_pixel_backprojection_unit dpb_checker u_dpb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_has_point (rsp_has_point),
   .rsp_point_x   (rsp_point_x),
   .rsp_point_y   (rsp_point_y),
   .rsp_point_z   (rsp_point_z)
);

`default_nettype wire
